>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RGB to NV21 converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> design/rgbnv_pkg.sv
// ----------------------------------------------------------------------------
// rgbnv_pkg
// Types and constants for the RGB888 to NV21 converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgbnv_pkg;

  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int LINE_WIDTH_W      = 13;
  localparam int SUM_W             = 9;
  localparam int PAIR_W            = 3 * SUM_W;

  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RESET = 13'd640;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_v;
    logic [7:0] chroma_u;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0] r;
    logic [SUM_W-1:0] g;
    logic [SUM_W-1:0] b;
  } pair_sum_t;

endpackage

>>> design/rgbnv_ram.sv
// ----------------------------------------------------------------------------
// rgbnv_ram
// Single-port RAM with write enable, read enable and registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgbnv_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [WIDTH-1:0]  wdata,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> design/rgb_to_nv21_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_nv21_converter_core
// Streaming RGB888 to NV21 (BT.601) converter with a line store of pair sums.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// word per pixel via the s1 and result registers. Every word carries the
// pixel's luma; the word of the odd-column pixel on an odd row also carries
// the V and U of its 2x2 block. The line store is a single-port RAM of
// MAX_WIDTH/2 entries, used once per odd-column pixel: written on even rows,
// read on odd rows, so it sets no limit below one pixel per clock. Assert
// frame_start on the first pixel of every frame. Write line_width (even,
// 2..MAX_WIDTH) only while no pixel is in flight and before a frame starts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rgb_to_nv21_converter_core
  import rgbnv_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [LINE_WIDTH_W-1:0] cfg_data,
  input  logic                    pixel_valid,
  output logic                    pixel_ready,
  input  pixel_t                  pixel,
  output logic                    result_valid,
  input  logic                    result_ready,
  output result_t                 result
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W  = (LINE_WIDTH_W > WW) ? LINE_WIDTH_W : WW;
  localparam int DEPTH  = MAX_WIDTH / 2;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LINE_WIDTH_W-1:0] line_width;
  logic [COL_W-1:0]        column_count;
  logic                    odd_row;
  logic [23:0]             held_pixel;

  logic                    s1_valid;
  logic                    s1_chroma;
  logic [23:0]             s1_rgb;
  pair_sum_t               s1_sum;

  logic [CMP_W-1:0]        lw_ext;
  logic [CMP_W-1:0]        lw_clamped;
  logic [WW-1:0]           eff_width;
  logic [COL_W-1:0]        col_cur;
  logic                    odd_cur;
  logic [WW-1:0]           col_plus;
  logic                    accept;
  logic                    s1_advance;
  pair_sum_t               sum_now;
  pair_sum_t               ram_rdata;
  logic                    ram_we;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_addr;

  logic [9:0]              tot_r;
  logic [9:0]              tot_g;
  logic [9:0]              tot_b;
  logic signed [17:0]      ar;
  logic signed [17:0]      ag;
  logic signed [17:0]      ab;
  logic signed [17:0]      u_acc;
  logic signed [17:0]      v_acc;
  logic signed [17:0]      u_sh;
  logic signed [17:0]      v_sh;
  logic [15:0]             y_acc;
  result_t                 result_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_width <= cfg_data;
    end
  end

  // clamp to 2..MAX_WIDTH and round down to even
  always_comb begin
    lw_ext = CMP_W'(line_width);
    if (lw_ext < CMP_W'(2)) begin
      lw_clamped = CMP_W'(2);
    end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
      lw_clamped = CMP_W'(MAX_WIDTH);
    end else begin
      lw_clamped = lw_ext;
    end
    eff_width = {lw_clamped[WW-1:1], 1'b0};
  end

  assign s1_advance  = s1_valid && (!result_valid || result_ready);
  assign pixel_ready = !s1_valid || s1_advance;
  assign accept      = pixel_valid && pixel_ready;

  assign col_cur  = pixel.frame_start ? '0 : column_count;
  assign odd_cur  = pixel.frame_start ? 1'b0 : odd_row;
  assign col_plus = WW'(col_cur) + WW'(1);

  assign sum_now.r = SUM_W'(held_pixel[23:16]) + SUM_W'(pixel.red);
  assign sum_now.g = SUM_W'(held_pixel[15:8]) + SUM_W'(pixel.green);
  assign sum_now.b = SUM_W'(held_pixel[7:0]) + SUM_W'(pixel.blue);

  assign ram_we   = accept && col_cur[0] && !odd_cur;
  assign ram_re   = accept && col_cur[0] && odd_cur;
  assign ram_addr = ADDR_W'(col_cur >> 1);

  rgbnv_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ram_addr),
    .wdata(sum_now),
    .rdata(ram_rdata)
  );

  // advance row and column position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      odd_row      <= 1'b0;
      held_pixel   <= '0;
    end else if (accept) begin
      if (!col_cur[0]) begin
        held_pixel <= {pixel.red, pixel.green, pixel.blue};
      end
      if (col_plus >= eff_width) begin
        column_count <= '0;
        odd_row      <= !odd_cur;
      end else begin
        column_count <= COL_W'(col_plus);
        odd_row      <= odd_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel_ready) begin
      s1_valid <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_rgb    <= {pixel.red, pixel.green, pixel.blue};
      s1_chroma <= col_cur[0] && odd_cur;
      s1_sum    <= sum_now;
    end
  end

  always_comb begin
    y_acc = 16'(s1_rgb[23:16]) * 16'd77 + 16'(s1_rgb[15:8]) * 16'd150
          + 16'(s1_rgb[7:0]) * 16'd29;
    tot_r = 10'(s1_sum.r) + 10'(ram_rdata.r);
    tot_g = 10'(s1_sum.g) + 10'(ram_rdata.g);
    tot_b = 10'(s1_sum.b) + 10'(ram_rdata.b);
    ar    = $signed(18'(tot_r[9:2]));
    ag    = $signed(18'(tot_g[9:2]));
    ab    = $signed(18'(tot_b[9:2]));
    u_acc = ab * 18'sd112 - ar * 18'sd38 - ag * 18'sd74;
    v_acc = ar * 18'sd112 - ag * 18'sd94 - ab * 18'sd18;
    u_sh  = (u_acc >>> 8) + 18'sd128;
    v_sh  = (v_acc >>> 8) + 18'sd128;

    result_next.luma         = y_acc[15:8];
    result_next.chroma_valid = s1_chroma;
    result_next.chroma_v     = s1_chroma ? v_sh[7:0] : 8'd0;
    result_next.chroma_u     = s1_chroma ? u_sh[7:0] : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result <= result_next;
    end
  end

  `ASSERT_SAME(a_no_chroma_zero, clk, rst, result_valid && !result.chroma_valid,
    result.chroma_v == 8'd0 && result.chroma_u == 8'd0, "chroma set without block")
  `ASSERT_SAME(a_chroma_range, clk, rst, result_valid && result.chroma_valid,
    result.chroma_v >= 8'd16 && result.chroma_v <= 8'd239 &&
    result.chroma_u >= 8'd16 && result.chroma_u <= 8'd239, "chroma out of range")
  `ASSERT_NEXT(a_block_end_flag, clk, rst, accept && col_cur[0] && odd_cur,
    s1_valid && s1_chroma, "block end not flagged")
  `ASSERT_NEXT(a_row_wrap, clk, rst, accept && col_plus >= eff_width,
    column_count == '0, "column not wrapped at line end")

endmodule
